FILE: rtl/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned LenW  = 3;
  localparam int unsigned CntW  = 2;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  // Lead byte classes
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  localparam logic [LenW-1:0] SeqLen2 = 3'd2;
  localparam logic [LenW-1:0] SeqLen3 = 3'd3;
  localparam logic [LenW-1:0] SeqLen4 = 3'd4;

endpackage

FILE: rtl/u8d_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_stream_if
// Valid/ready channels of the decoder: raw bytes in, code points out.
// ----------------------------------------------------------------------------
interface u8d_in_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::ByteW-1:0]  data_byte;
  logic                       end_flag;

  modport source (output valid, output data_byte, output end_flag, input ready);
  modport sink   (input valid, input data_byte, input end_flag, output ready);
endinterface

interface u8d_out_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::CpW-1:0]    code_point;
  logic                       is_replacement;
  logic                       last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface

FILE: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Lenient UTF-8 decoder with byte-wise U+FFFD replacement.
// ----------------------------------------------------------------------------
// in_i carries one text byte per word, or an end marker (end_flag) that
// flushes an unfinished sequence. out_o gives zero to four code point words
// per input word; last_of_run marks the final word caused by one input word.
// An input word lands in an input register; the decode logic reads it with
// the sequence state and, once the result buffer (a count of pending
// replacements plus one tail code point) is free, loads that buffer.
// Input accept reaches the output through the input register, then the buffer.
// Throughput: one input word per cycle while each causes at most one output
// word and the receiver is ready; a word that causes several results holds the
// input register until the single output port, draining one word per cycle,
// pops its last one. When the receiver stalls, the result buffer holds; the
// input register takes a word only while empty, and in_i.ready then drops.
// Reset clears the sequence state and the valid flags of the input register
// and the buffer; the block is ready for words as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  u8d_in_if.sink         in_i,
  u8d_out_if.source      out_o
);

  // input register
  logic                        in_valid_q;
  logic [u8d_pkg::ByteW-1:0]   in_byte_q;
  logic                        in_end_q;

  // sequence state
  logic [u8d_pkg::LenW-1:0]    exp_len_q, exp_len_d;
  logic [u8d_pkg::CntW-1:0]    rcv_cnt_q, rcv_cnt_d;
  logic [u8d_pkg::CpW-1:0]     acc_q, acc_d;

  // result buffer
  logic [u8d_pkg::CntW-1:0]    rep_cnt_q, rep_cnt_d;
  logic                        tail_valid_q, tail_valid_d;
  logic [u8d_pkg::CpW-1:0]     tail_cp_q, tail_cp_d;
  logic                        tail_rep_q, tail_rep_d;

  logic                        buf_empty, buf_last, buf_free, load, pop;
  logic                        is_cont, seq_open;
  logic [u8d_pkg::CntW-1:0]    cnt_inc;
  logic [u8d_pkg::CpW-1:0]     acc_shift;
  logic                        take_lead;

  assign buf_empty = (rep_cnt_q == '0) && !tail_valid_q;
  assign buf_last  = (rep_cnt_q == '0) || ((rep_cnt_q == 2'd1) && !tail_valid_q);
  assign pop       = out_o.valid && out_o.ready;
  assign buf_free  = buf_empty || (pop && buf_last);
  assign load      = in_valid_q && buf_free;

  assign in_i.ready = !in_valid_q || load;

  assign out_o.valid          = !buf_empty;
  assign out_o.code_point     = (rep_cnt_q != '0) ? u8d_pkg::ReplChar : tail_cp_q;
  assign out_o.is_replacement = (rep_cnt_q != '0) ? 1'b1 : tail_rep_q;
  assign out_o.last_of_run    = buf_last;

  assign is_cont   = (in_byte_q[7:6] == 2'b10);
  assign seq_open  = (exp_len_q != '0);
  assign cnt_inc   = rcv_cnt_q + 2'd1;
  assign acc_shift = {acc_q[u8d_pkg::CpW-7:0], in_byte_q[5:0]};

  always_comb begin
    exp_len_d    = exp_len_q;
    rcv_cnt_d    = rcv_cnt_q;
    acc_d        = acc_q;
    rep_cnt_d    = rep_cnt_q;
    tail_valid_d = tail_valid_q;
    tail_cp_d    = tail_cp_q;
    tail_rep_d   = tail_rep_q;
    take_lead    = 1'b0;

    // drain one word
    if (pop) begin
      if (rep_cnt_q != '0) begin
        rep_cnt_d = rep_cnt_q - 2'd1;
      end else begin
        tail_valid_d = 1'b0;
      end
    end

    if (load) begin
      rep_cnt_d    = '0;
      tail_valid_d = 1'b0;
      tail_cp_d    = u8d_pkg::ReplChar;
      tail_rep_d   = 1'b1;
      if (in_end_q) begin
        rep_cnt_d = rcv_cnt_q;
        exp_len_d = '0;
        rcv_cnt_d = '0;
        acc_d     = '0;
      end else if (seq_open && is_cont) begin
        acc_d     = acc_shift;
        rcv_cnt_d = cnt_inc;
        // a four byte sequence wraps the count to zero
        if (({1'b0, cnt_inc} == exp_len_q) || (cnt_inc == '0)) begin
          tail_valid_d = 1'b1;
          tail_cp_d    = acc_shift;
          tail_rep_d   = 1'b0;
          exp_len_d    = '0;
          rcv_cnt_d    = '0;
          acc_d        = '0;
        end
      end else begin
        // no open or a broken sequence: replace every buffered byte, then restart here
        rep_cnt_d = seq_open ? rcv_cnt_q : '0;
        exp_len_d = '0;
        rcv_cnt_d = '0;
        acc_d     = '0;
        take_lead = 1'b1;
      end

      if (take_lead) begin
        if (!in_byte_q[7]) begin
          tail_valid_d = 1'b1;
          tail_cp_d    = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, in_byte_q};
          tail_rep_d   = 1'b0;
        end else if ((in_byte_q & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
          acc_d     = {{(u8d_pkg::CpW-5){1'b0}}, in_byte_q[4:0]};
          exp_len_d = u8d_pkg::SeqLen2;
          rcv_cnt_d = 2'd1;
        end else if ((in_byte_q & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
          acc_d     = {{(u8d_pkg::CpW-4){1'b0}}, in_byte_q[3:0]};
          exp_len_d = u8d_pkg::SeqLen3;
          rcv_cnt_d = 2'd1;
        end else if ((in_byte_q & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
          acc_d     = {{(u8d_pkg::CpW-3){1'b0}}, in_byte_q[2:0]};
          exp_len_d = u8d_pkg::SeqLen4;
          rcv_cnt_d = 2'd1;
        end else begin
          tail_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      exp_len_q    <= '0;
      rcv_cnt_q    <= '0;
      acc_q        <= '0;
      rep_cnt_q    <= '0;
      tail_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      exp_len_q    <= exp_len_d;
      rcv_cnt_q    <= rcv_cnt_d;
      acc_q        <= acc_d;
      rep_cnt_q    <= rep_cnt_d;
      tail_valid_q <= tail_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_end_q  <= in_i.end_flag;
    end
    tail_cp_q  <= tail_cp_d;
    tail_rep_q <= tail_rep_d;
  end

endmodule

FILE: rtl/u8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the UTF-8 stream decoder output channel.
// ----------------------------------------------------------------------------
module u8d_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [u8d_pkg::CpW-1:0]   code_point_i,
  input  logic                      is_replacement_i,
  input  logic                      last_of_run_i
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_point_i)
      && $stable(is_replacement_i) && $stable(last_of_run_i))
    else $error("stalled output word changed");

  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_replacement_i |-> code_point_i == u8d_pkg::ReplChar)
    else $error("replacement flag without U+FFFD");

  // only replacements precede the final word of a run
  a_mid_is_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> is_replacement_i)
    else $error("non-final word is not a replacement");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=> out_valid_i)
    else $error("run ended without a final word");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .code_point_i     (out_o.code_point),
  .is_replacement_i (out_o.is_replacement),
  .last_of_run_i    (out_o.last_of_run)
);
